### rtl/core/icsf_pkg.sv
// Shared types and constants of the isolated cell smoothing filter.
// No dependencies; every other file of the block but icsf_store uses this package.
package icsf_pkg;

  // default geometry and height width
  localparam int unsigned MAX_WIDTH_DEF   = 64;
  localparam int unsigned MAX_HEIGHT_DEF  = 64;
  localparam int unsigned HEIGHT_BITS_DEF = 8;

  // fixed field widths
  localparam int unsigned OPCODE_BITS = 2;
  localparam int unsigned COORD_BITS  = 6;
  localparam int unsigned COORD_RANGE = 1 << COORD_BITS;
  localparam int unsigned WHEIGHT_BITS = 8;
  localparam int unsigned RHEIGHT_BITS = 8;
  localparam int unsigned CFG_BITS    = 7;
  localparam int unsigned CFG_IDX_BITS = 1;

  // operation codes
  localparam logic [OPCODE_BITS-1:0] OP_WRITE  = 2'd0;
  localparam logic [OPCODE_BITS-1:0] OP_SMOOTH = 2'd1;
  localparam logic [OPCODE_BITS-1:0] OP_READ   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAP_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAP_HEIGHT = 1'b1;
  localparam logic [CFG_BITS-1:0]     CFG_SIZE_RESET = 7'd64;

  // finished item, from the sequencer to the output register
  typedef struct packed {
    logic                    valid;
    logic [RHEIGHT_BITS-1:0] read_height;
  } rsp_t;

endpackage

### rtl/core/icsf_if.sv
// Request and response channel interfaces of the smoothing filter.
// Depends on icsf_pkg for the field widths.
interface icsf_req_if;
  logic                                valid;
  logic                                ready;
  logic [icsf_pkg::OPCODE_BITS-1:0]    opcode;
  logic [icsf_pkg::COORD_BITS-1:0]     column;
  logic [icsf_pkg::COORD_BITS-1:0]     row;
  logic [icsf_pkg::WHEIGHT_BITS-1:0]   write_height;

  modport source (output valid, opcode, column, row, write_height, input ready);
  modport sink   (input valid, opcode, column, row, write_height, output ready);
endinterface

interface icsf_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [icsf_pkg::RHEIGHT_BITS-1:0]   read_height;
  logic                                op_done;

  modport source (output valid, read_height, op_done, input ready);
  modport sink   (input valid, read_height, op_done, output ready);
endinterface

### rtl/core/icsf_store.sv
// Height store: one write port, one read port, registered read data.
// No package dependencies.
module icsf_store #(
  parameter int unsigned AddrBits = 12,
  parameter int unsigned DataBits = 8
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [DataBits-1:0] wdata_i,
  input  logic                re_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [DataBits-1:0] rdata_o
);

  localparam int unsigned Depth = 1 << AddrBits;

  logic [DataBits-1:0] mem_q [Depth];
  logic [DataBits-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/icsf_seq.sv
// Request sequencer: tile read/write and the in-place smoothing scan.
// Depends on icsf_pkg and icsf_req_if; drives the ports of icsf_store.
module icsf_seq #(
  parameter int unsigned MAX_WIDTH   = icsf_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT  = icsf_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned HEIGHT_BITS = icsf_pkg::HEIGHT_BITS_DEF,
  parameter int unsigned ColBits     = $clog2(MAX_WIDTH),
  parameter int unsigned RowBits     = $clog2(MAX_HEIGHT)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  icsf_req_if.sink                            req,
  input  logic [icsf_pkg::CFG_BITS-1:0]       map_width_i,
  input  logic [icsf_pkg::CFG_BITS-1:0]       map_height_i,
  input  logic                                slot_free_i,
  output icsf_pkg::rsp_t                      rsp_o,
  output logic                                we_o,
  output logic [RowBits+ColBits-1:0]          waddr_o,
  output logic [HEIGHT_BITS-1:0]              wdata_o,
  output logic                                re_o,
  output logic [RowBits+ColBits-1:0]          raddr_o,
  input  logic [HEIGHT_BITS-1:0]              rdata_i
);
  import icsf_pkg::*;

  localparam int unsigned AddrBits = RowBits + ColBits;
  localparam int unsigned CmpBits  = 10;
  localparam logic [2:0]  PH_SELF  = 3'd0;
  localparam logic [2:0]  PH_LEFT  = 3'd1;
  localparam logic [2:0]  PH_RIGHT = 3'd2;
  localparam logic [2:0]  PH_UP    = 3'd3;
  localparam logic [2:0]  PH_DOWN  = 3'd4;
  localparam logic [2:0]  PH_EVAL  = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_RESP = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [2:0]           phase_q, phase_d;
  logic [ColBits-1:0]   x_q, x_d;
  logic [RowBits-1:0]   y_q, y_d;
  logic [OPCODE_BITS-1:0] op_q, op_d;
  logic [HEIGHT_BITS-1:0] self_q, left_q, right_q, up_q;

  // input coordinate wrap onto the physical store
  logic [ColBits-1:0] col_tab [COORD_RANGE];
  logic [RowBits-1:0] row_tab [COORD_RANGE];
  for (genvar k = 0; k < COORD_RANGE; k++) begin : g_wrap
    assign col_tab[k] = ColBits'(k % MAX_WIDTH);
    assign row_tab[k] = RowBits'(k % MAX_HEIGHT);
  end

  logic [AddrBits-1:0] req_addr;
  assign req_addr = {row_tab[req.row], col_tab[req.column]};

  // last column and row in use, sizes clamped to 1..MAX
  logic [CmpBits-1:0] wv, hv;
  logic [ColBits-1:0] last_col;
  logic [RowBits-1:0] last_row;
  always_comb begin
    wv = CmpBits'(map_width_i);
    hv = CmpBits'(map_height_i);
    if (wv == '0) begin
      last_col = '0;
    end else if (wv > CmpBits'(MAX_WIDTH)) begin
      last_col = ColBits'(MAX_WIDTH - 1);
    end else begin
      last_col = ColBits'(wv - CmpBits'(1));
    end
    if (hv == '0) begin
      last_row = '0;
    end else if (hv > CmpBits'(MAX_HEIGHT)) begin
      last_row = RowBits'(MAX_HEIGHT - 1);
    end else begin
      last_row = RowBits'(hv - CmpBits'(1));
    end
  end

  // torus neighbors of the scan position
  logic [ColBits-1:0] x_left, x_right;
  logic [RowBits-1:0] y_up, y_down;
  assign x_left  = (x_q == '0) ? last_col : x_q - ColBits'(1);
  assign x_right = (x_q == last_col) ? '0 : x_q + ColBits'(1);
  assign y_up    = (y_q == '0) ? last_row : y_q - RowBits'(1);
  assign y_down  = (y_q == last_row) ? '0 : y_q + RowBits'(1);

  logic accept;
  logic isolated;
  assign req.ready = (state_q == ST_IDLE);
  assign accept    = req.valid && req.ready;
  // down value arrives in the eval phase; all four must differ
  assign isolated  = (left_q != self_q) && (right_q != self_q) &&
                     (up_q != self_q) && (rdata_i != self_q);

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    x_d     = x_q;
    y_d     = y_q;
    op_d    = op_q;
    we_o    = 1'b0;
    waddr_o = req_addr;
    wdata_o = HEIGHT_BITS'(req.write_height);
    re_o    = 1'b0;
    raddr_o = req_addr;
    rsp_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d = req.opcode;
          we_o = (req.opcode == OP_WRITE);
          re_o = (req.opcode == OP_READ);
          if (req.opcode == OP_SMOOTH) begin
            state_d = ST_SCAN;
            phase_d = PH_SELF;
            x_d     = '0;
            y_d     = '0;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_SCAN: begin
        case (phase_q)
          PH_SELF:  raddr_o = {y_q, x_q};
          PH_LEFT:  raddr_o = {y_q, x_left};
          PH_RIGHT: raddr_o = {y_q, x_right};
          PH_UP:    raddr_o = {y_up, x_q};
          PH_DOWN:  raddr_o = {y_down, x_q};
          default:  raddr_o = {y_q, x_q};
        endcase
        if (phase_q == PH_EVAL) begin
          we_o    = isolated;
          waddr_o = {y_q, x_q};
          wdata_o = rdata_i;
          phase_d = PH_SELF;
          if (x_q == last_col) begin
            x_d = '0;
            if (y_q == last_row) begin
              y_d     = '0;
              state_d = ST_RESP;
            end else begin
              y_d = y_q + RowBits'(1);
            end
          end else begin
            x_d = x_q + ColBits'(1);
          end
        end else begin
          re_o    = 1'b1;
          phase_d = phase_q + 3'd1;
        end
      end
      ST_RESP: begin
        if (slot_free_i) begin
          rsp_o.valid       = 1'b1;
          rsp_o.read_height = (op_q == OP_READ) ? RHEIGHT_BITS'(rdata_i) : '0;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_SELF;
      x_q     <= '0;
      y_q     <= '0;
      op_q    <= OP_WRITE;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      x_q     <= x_d;
      y_q     <= y_d;
      op_q    <= op_d;
    end
  end

  // capture the neighborhood as read data returns
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCAN) begin
      case (phase_q)
        PH_LEFT:  self_q  <= rdata_i;
        PH_RIGHT: left_q  <= rdata_i;
        PH_UP:    right_q <= rdata_i;
        PH_DOWN:  up_q    <= rdata_i;
        default:  ;
      endcase
    end
  end

endmodule

### rtl/core/isolated_cell_smoothing_filter.sv
// Top level of the isolated cell smoothing filter: configuration registers,
// output register, sequencer and height store.
// Depends on icsf_pkg, icsf_if, icsf_store and icsf_seq.
//
// Usage
//   req_i carries one request: opcode (write tile, smoothing pass, read tile),
//   column, row and write_height. rsp_o returns exactly one response per
//   request: read_height (the tile for a read, zero otherwise) and op_done.
//   The map size registers are written through cfg_we_i / cfg_index_i /
//   cfg_wdata_i; the user must do so only while no request is in flight,
//   the block does not enforce it. 0 counts as 1, values above the store
//   size count as the store size.
// Request flow
//   One request at a time: a write or read goes from acceptance to the
//   response state, then to the output register. A smoothing pass first
//   scans every tile: five reads on the one read port, then the write-back.
// Reset
//   Sizes return to 64x64 and the sequencer to idle. The store keeps no reset
//   value; tiles must be written before they are read or smoothed.
// Back-pressure
//   A finished response waits in the output register; the next request is
//   still taken and worked on, and only its response stalls until rsp_o.ready.
module isolated_cell_smoothing_filter #(
  parameter int unsigned MAX_WIDTH   = icsf_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT  = icsf_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned HEIGHT_BITS = icsf_pkg::HEIGHT_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [icsf_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [icsf_pkg::CFG_BITS-1:0]        cfg_wdata_i,
  icsf_req_if.sink                             req_i,
  icsf_rsp_if.source                           rsp_o
);
  import icsf_pkg::*;

  localparam int unsigned ColBits  = $clog2(MAX_WIDTH);
  localparam int unsigned RowBits  = $clog2(MAX_HEIGHT);
  localparam int unsigned AddrBits = ColBits + RowBits;

  // size registers
  logic [CFG_BITS-1:0] map_width_q, map_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= CFG_SIZE_RESET;
      map_height_q <= CFG_SIZE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MAP_WIDTH:  map_width_q  <= cfg_wdata_i;
        CFG_MAP_HEIGHT: map_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // store access
  logic                   st_we, st_re;
  logic [AddrBits-1:0]    st_waddr, st_raddr;
  logic [HEIGHT_BITS-1:0] st_wdata, st_rdata;

  icsf_store #(
    .AddrBits (AddrBits),
    .DataBits (HEIGHT_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // response register
  logic                    out_valid_q;
  logic [RHEIGHT_BITS-1:0] out_height_q;
  logic                    slot_free;
  rsp_t                    seq_rsp;

  assign slot_free = !out_valid_q || rsp_o.ready;

  icsf_seq #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .HEIGHT_BITS (HEIGHT_BITS),
    .ColBits     (ColBits),
    .RowBits     (RowBits)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req_i),
    .map_width_i  (map_width_q),
    .map_height_i (map_height_q),
    .slot_free_i  (slot_free),
    .rsp_o        (seq_rsp),
    .we_o         (st_we),
    .waddr_o      (st_waddr),
    .wdata_o      (st_wdata),
    .re_o         (st_re),
    .raddr_o      (st_raddr),
    .rdata_i      (st_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq_rsp.valid) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_rsp.valid) begin
      out_height_q <= seq_rsp.read_height;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.read_height = out_height_q;
  assign rsp_o.op_done     = 1'b1;

endmodule

### tb/icsf_map_checker.sv
`timescale 1ns / 1ps
// Checker for the isolated cell smoothing filter: keeps its own copy of the
// height map and size registers, predicts every response and compares it.
// Depends on icsf_pkg and the icsf_req_if / icsf_rsp_if channel interfaces.
module icsf_map_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [icsf_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [icsf_pkg::CFG_BITS-1:0]     cfg_wdata_i,
  icsf_req_if                               req_mon,
  icsf_rsp_if                               rsp_mon,
  output int unsigned                       fail_count_o,
  output int unsigned                       owed_count_o,
  output int unsigned                       replaced_count_o
);
  import icsf_pkg::*;

  localparam int unsigned STRIDE = MAX_WIDTH_DEF;
  localparam int unsigned DEPTH  = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;

  typedef struct packed {
    logic [RHEIGHT_BITS-1:0] read_height;
    logic                    op_done;
  } tile_rsp_t;

  logic [HEIGHT_BITS_DEF-1:0] tile_mem [DEPTH];
  logic [CFG_BITS-1:0]        width_reg;
  logic [CFG_BITS-1:0]        height_reg;
  tile_rsp_t                  owed_rsp_q [$];
  int unsigned                fails;
  int unsigned                replaced;

  // 0 counts as 1, anything past the store counts as the store size
  function automatic int unsigned live_span(logic [CFG_BITS-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  // one in-place raster pass; a tile with no equal neighbor takes the down one
  function automatic void relax_isolated_tiles();
    int unsigned w;
    int unsigned h;
    int unsigned hits;
    logic [HEIGHT_BITS_DEF-1:0] nb [4];
    w = live_span(width_reg, MAX_WIDTH_DEF);
    h = live_span(height_reg, MAX_HEIGHT_DEF);
    for (int unsigned r = 0; r < h; r++) begin
      for (int unsigned c = 0; c < w; c++) begin
        nb[0] = tile_mem[r * STRIDE + (c + w - 1) % w];
        nb[1] = tile_mem[r * STRIDE + (c + 1) % w];
        nb[2] = tile_mem[((r + h - 1) % h) * STRIDE + c];
        nb[3] = tile_mem[((r + 1) % h) * STRIDE + c];
        hits = 0;
        foreach (nb[k]) begin
          if (nb[k] == tile_mem[r * STRIDE + c]) hits++;
        end
        if (hits == 0) begin
          tile_mem[r * STRIDE + c] = nb[3];
          replaced++;
        end
      end
    end
  endfunction

  function automatic tile_rsp_t predict_request(logic [OPCODE_BITS-1:0] op,
                                                logic [COORD_BITS-1:0] col,
                                                logic [COORD_BITS-1:0] row,
                                                logic [WHEIGHT_BITS-1:0] wh);
    tile_rsp_t r;
    r.read_height = '0;
    r.op_done     = 1'b1;
    case (op)
      OP_WRITE:  tile_mem[row * STRIDE + col] = wh[HEIGHT_BITS_DEF-1:0];
      OP_SMOOTH: relax_isolated_tiles();
      OP_READ:   r.read_height = tile_mem[row * STRIDE + col];
      default:   ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    tile_rsp_t want;
    if (!rst_ni) begin
      width_reg  = CFG_SIZE_RESET;
      height_reg = CFG_SIZE_RESET;
      owed_rsp_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_MAP_WIDTH) width_reg = cfg_wdata_i;
        else height_reg = cfg_wdata_i;
      end
      if (req_mon.valid && req_mon.ready) begin
        owed_rsp_q.push_back(predict_request(req_mon.opcode, req_mon.column,
                                             req_mon.row, req_mon.write_height));
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (owed_rsp_q.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("%0t: response with nothing owed: read_height=%0d op_done=%b",
                     $time, rsp_mon.read_height, rsp_mon.op_done);
          end
        end else begin
          want = owed_rsp_q.pop_front();
          if (rsp_mon.read_height !== want.read_height ||
              rsp_mon.op_done !== want.op_done) begin
            fails++;
            if (fails <= 10) begin
              $display("%0t: mismatch: read_height exp %0d got %0d, op_done exp %b got %b",
                       $time, want.read_height, rsp_mon.read_height,
                       want.op_done, rsp_mon.op_done);
            end
          end
        end
      end
    end
    owed_count_o     <= owed_rsp_q.size();
    fail_count_o     <= fails;
    replaced_count_o <= replaced;
  end

endmodule

### tb/isolated_cell_smoothing_filter_tb.sv
`timescale 1ns / 1ps
// Top of the smoothing filter testbench: clock, reset, request stimulus,
// response back-pressure, map size programming and the verdict.
// Depends on icsf_pkg, the channel interfaces, the RTL and icsf_map_checker.
module isolated_cell_smoothing_filter_tb;
  import icsf_pkg::*;

  // opcode the block does not define; it must still answer with op_done
  localparam logic [OPCODE_BITS-1:0] OP_SPARE = 2'd3;

  // map sizes per random phase, {width, height} as written to the registers;
  // 0 and values past 64 exercise the clamping, 64x64 is left out since a
  // pass over it would need the whole store written first
  localparam int unsigned PHASES = 12;
  localparam logic [2*CFG_BITS-1:0] SIZE_PLAN [PHASES] = '{
    {7'd4,   7'd4},   {7'd1,  7'd1},   {7'd64, 7'd1},   {7'd2,   7'd64},
    {7'd127, 7'd2},   {7'd5,  7'd0},   {7'd8,  7'd8},   {7'd64,  7'd3},
    {7'd3,   7'd5},   {7'd1,  7'd127}, {7'd0,  7'd0},   {7'd65,  7'd4}
  };
  localparam int unsigned RANDOM_PER_PHASE = 60;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_index_i;
  logic [CFG_BITS-1:0]     cfg_wdata_i;

  icsf_req_if req_ch ();
  icsf_rsp_if rsp_ch ();

  int unsigned mismatch_count;
  int unsigned owed_count;
  int unsigned replaced_count;

  // stimulus-side bookkeeping
  bit                 written_map [MAX_WIDTH_DEF * MAX_HEIGHT_DEF];
  int unsigned        span_w = MAX_WIDTH_DEF;
  int unsigned        span_h = MAX_HEIGHT_DEF;
  logic [7:0]         palette [3];
  bit                 steady;
  int unsigned        op_tally [4];
  int unsigned        sizes_run;

  always #2 clk_i = ~clk_i;

  isolated_cell_smoothing_filter dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  icsf_map_checker checker_u (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .req_mon          (req_ch),
    .rsp_mon          (rsp_ch),
    .fail_count_o     (mismatch_count),
    .owed_count_o     (owed_count),
    .replaced_count_o (replaced_count)
  );

  // Response back-pressure: alternating open and stalled runs, with the odd
  // long stall; open runs are sometimes long enough to give stretches with
  // no stall at all.
  bit          ready_now;
  int unsigned ready_left;

  initial rsp_ch.ready = 1'b0;

  always @(posedge clk_i) begin
    if (ready_left != 0) begin
      ready_left--;
    end else begin
      ready_now = !ready_now;
      if (!ready_now) begin
        ready_left = ($urandom_range(0, 99) < 92) ? $urandom_range(0, 2)
                                                  : $urandom_range(10, 50);
      end else begin
        ready_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 10)
                                                  : $urandom_range(100, 300);
      end
    end
    rsp_ch.ready <= ready_now;
  end

  // Heights mostly from a small per-phase palette so that neighbors often
  // match and the pass has both isolated and non-isolated tiles to handle.
  function automatic logic [7:0] pick_height();
    if ($urandom_range(0, 99) < 70) return palette[$urandom_range(0, 2)];
    return 8'($urandom());
  endfunction

  // Present one request, hold it until taken, then maybe idle a while.
  // valid stays high across back-to-back requests (no drop and re-raise
  // within one step).
  task automatic issue(input logic [OPCODE_BITS-1:0] op,
                       input logic [COORD_BITS-1:0] col,
                       input logic [COORD_BITS-1:0] row,
                       input logic [WHEIGHT_BITS-1:0] hgt);
    int unsigned gap;
    int unsigned roll;
    req_ch.valid        <= 1'b1;
    req_ch.opcode       <= op;
    req_ch.column       <= col;
    req_ch.row          <= row;
    req_ch.write_height <= hgt;
    do @(posedge clk_i); while (!req_ch.ready);
    op_tally[op]++;
    if (op == OP_WRITE) written_map[{row, col}] = 1'b1;
    roll = $urandom_range(0, 99);
    if (steady || roll < 50) gap = 0;
    else if (roll < 85) gap = $urandom_range(1, 3);
    else if (roll < 97) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 60);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every owed response has been taken. The
  // first edge lets the checker count a request taken at the current edge.
  task automatic wait_drained();
    if (req_ch.valid) req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (owed_count != 0);
  endtask

  // Write both size registers on consecutive edges; only legal when idle.
  task automatic program_map(input logic [CFG_BITS-1:0] wv, input logic [CFG_BITS-1:0] hv);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_MAP_WIDTH;
    cfg_wdata_i <= wv;
    @(posedge clk_i);
    cfg_index_i <= CFG_MAP_HEIGHT;
    cfg_wdata_i <= hv;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    span_w = (wv == 0) ? 1 : ((wv > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : wv);
    span_h = (hv == 0) ? 1 : ((hv > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : hv);
    sizes_run++;
  endtask

  initial begin : stimulus
    int unsigned         roll;
    int unsigned         tries;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;

    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_index_i         = CFG_MAP_WIDTH;
    cfg_wdata_i         = '0;
    req_ch.valid        = 1'b0;
    req_ch.opcode       = OP_WRITE;
    req_ch.column       = '0;
    req_ch.row          = '0;
    req_ch.write_height = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part ---
    // store corners and both height extremes under the reset size (64x64)
    sizes_run = 1;
    issue(OP_WRITE, 6'd0,  6'd0,  8'h00);
    issue(OP_WRITE, 6'd63, 6'd63, 8'hFF);
    issue(OP_WRITE, 6'd63, 6'd0,  8'hAA);
    issue(OP_WRITE, 6'd0,  6'd63, 8'h55);
    issue(OP_READ,  6'd0,  6'd0,  8'hFF);
    issue(OP_READ,  6'd63, 6'd63, 8'h00);
    issue(OP_READ,  6'd63, 6'd0,  8'h00);
    issue(OP_READ,  6'd0,  6'd63, 8'h00);
    // undefined opcode: no side effect, zero height, op_done still set
    issue(OP_SPARE, 6'd63, 6'd63, 8'hFF);

    // 3x3 torus with an isolated center; the tile below it differs from
    // the rest, so the center takes the down value and the tile below then
    // sees its updated up neighbor within the same pass
    wait_drained();
    program_map(7'd3, 7'd3);
    for (int unsigned r = 0; r < 3; r++) begin
      for (int unsigned c = 0; c < 3; c++) begin
        issue(OP_WRITE, 6'(c), 6'(r),
              (c == 1 && r == 1) ? 8'd200 : ((c == 1 && r == 2) ? 8'd9 : 8'd7));
      end
    end
    issue(OP_SMOOTH, 6'd17, 6'd42, 8'h3C);
    issue(OP_READ, 6'd1, 6'd1, 8'h00);

    // width 0 counts as one column: left and right wrap onto the tile
    // itself, so nothing may change
    wait_drained();
    program_map(7'd0, 7'd2);
    issue(OP_WRITE, 6'd0, 6'd0, 8'd1);
    issue(OP_WRITE, 6'd0, 6'd1, 8'd2);
    issue(OP_SMOOTH, 6'd0, 6'd0, 8'h00);
    issue(OP_READ, 6'd0, 6'd1, 8'h00);

    // --- random phases ---
    for (int unsigned p = 0; p < PHASES; p++) begin
      wait_drained();
      program_map(SIZE_PLAN[p][2*CFG_BITS-1:CFG_BITS], SIZE_PLAN[p][CFG_BITS-1:0]);
      steady     = ($urandom_range(0, 3) == 0);
      palette[0] = 8'($urandom());
      palette[1] = 8'($urandom());
      palette[2] = ($urandom_range(0, 1) == 0) ? palette[0] : 8'($urandom());

      // every tile of the map in use gets written before any pass reads it
      for (int unsigned r = 0; r < span_h; r++) begin
        for (int unsigned c = 0; c < span_w; c++) begin
          issue(OP_WRITE, 6'(c), 6'(r), pick_height());
        end
      end

      for (int unsigned n = 0; n < RANDOM_PER_PHASE; n++) begin
        // sender holds off until the block has drained, at least once
        if ((p == 0 && n == RANDOM_PER_PHASE / 2) || $urandom_range(0, 39) == 0) begin
          wait_drained();
        end
        roll = $urandom_range(0, 99);
        col  = 6'($urandom());
        row  = 6'($urandom());
        if (roll < 10) begin
          issue(OP_SMOOTH, col, row, 8'($urandom()));
        end else if (roll < 15) begin
          issue(OP_SPARE, col, row, 8'($urandom()));
        end else if (roll < 55) begin
          // mostly inside the map in use, else anywhere in the store
          if ($urandom_range(0, 9) < 7) begin
            col = 6'($urandom_range(0, span_w - 1));
            row = 6'($urandom_range(0, span_h - 1));
          end
          issue(OP_WRITE, col, row, pick_height());
        end else begin
          // reads only hit tiles already written
          tries = 0;
          while (!written_map[{row, col}] && tries < 8) begin
            col = 6'($urandom());
            row = 6'($urandom());
            tries++;
          end
          if (!written_map[{row, col}] || $urandom_range(0, 1) == 0) begin
            col = 6'($urandom_range(0, span_w - 1));
            row = 6'($urandom_range(0, span_h - 1));
          end
          issue(OP_READ, col, row, 8'($urandom()));
        end
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("run: %0d writes, %0d reads, %0d smoothing passes, %0d undefined-opcode requests",
             op_tally[OP_WRITE], op_tally[OP_READ], op_tally[OP_SMOOTH], op_tally[OP_SPARE]);
    $display("run: %0d map sizes, %0d tiles replaced by smoothing", sizes_run, replaced_count);
    if (mismatch_count == 0 && owed_count == 0) begin
      $display("isolated_cell_smoothing_filter verification clean");
    end else begin
      $display("isolated_cell_smoothing_filter verification failed");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin : watchdog
    #8000000;
    $display("isolated_cell_smoothing_filter verification failed");
    $finish;
  end

endmodule

### sim.f
rtl/core/icsf_pkg.sv
rtl/core/icsf_if.sv
rtl/core/icsf_store.sv
rtl/core/icsf_seq.sv
rtl/core/isolated_cell_smoothing_filter.sv
tb/icsf_map_checker.sv
tb/isolated_cell_smoothing_filter_tb.sv
